// ===== src/transient_occupancy_grid_core_macros.svh =====
`ifndef TRANSIENT_OCCUPANCY_GRID_CORE_MACROS_SVH
`define TRANSIENT_OCCUPANCY_GRID_CORE_MACROS_SVH
// same-cycle implication, off during reset
`define TOGC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("togc assertion failed");
// next-cycle implication, off during reset
`define TOGC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("togc assertion failed");
// next-cycle implication, active during reset too
`define TOGC_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("togc assertion failed");
`endif

// ===== src/togc_pkg.sv =====
`default_nettype none
package togc_pkg;

    localparam logic [1:0] ACT_MARK  = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CHECK = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [1:0] REG_DECAY  = 2'd0;
    localparam logic [1:0] REG_LOOK   = 2'd1;
    localparam logic [1:0] REG_THRESH = 2'd2;

    localparam logic [1:0] STEER_NONE  = 2'b00;
    localparam logic [1:0] STEER_RIGHT = 2'b01;
    localparam logic [1:0] STEER_LEFT  = 2'b11;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]         action;
        logic [15:0]        pos_x;
        logic [15:0]        pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_z;
        logic [15:0]        uid;
        logic               id_odd;
        logic [15:0]        tick;
        logic [2:0]         half;
    } cmd_t;

    typedef struct packed {
        logic [15:0] decay_ticks;
        logic [3:0]  lookahead_cells;
        logic [15:0] motion_threshold;
    } cfg_t;

    typedef struct packed {
        logic [2:0] right_count;
        logic [2:0] left_count;
        logic [1:0] center_count;
        logic       occupied;
        logic [1:0] steer;
    } result_t;

endpackage
`default_nettype wire

// ===== src/togc_queue.sv =====
`default_nettype none
module togc_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  togc_pkg::cmd_t     din,
    output logic               full,
    output logic               valid,
    input  wire logic          pop,
    output togc_pkg::cmd_t     dout
);
    import togc_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    cmd_t            entries_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== src/togc_front.sv =====
`default_nettype none
module togc_front #(
    parameter int MAX_FOOTPRINT = 7
) (
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [135:0]  s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          q_full,
    input  wire logic          init_busy,
    output logic               push,
    output togc_pkg::cmd_t     cmd
);
    import togc_pkg::*;

    logic [2:0]  fp_raw;
    logic [2:0]  fp_clamped;
    logic [15:0] raw_id;

    assign s_tready = !q_full && !init_busy;
    assign push     = s_tvalid && s_tready;

    assign fp_raw = s_tdata[130:128];
    assign raw_id = s_tdata[111:96];

    always_comb begin
        if ({1'b0, fp_raw} > 4'(MAX_FOOTPRINT)) begin
            fp_clamped = 3'(MAX_FOOTPRINT);
        end else begin
            fp_clamped = fp_raw;
        end
        cmd.action = s_tuser;
        cmd.pos_x  = s_tdata[15:0];
        cmd.pos_z  = s_tdata[31:16];
        cmd.vel_x  = s_tdata[47:32];
        cmd.vel_z  = s_tdata[63:48];
        cmd.fwd_x  = s_tdata[79:64];
        cmd.fwd_z  = s_tdata[95:80];
        cmd.uid    = (raw_id == 16'd0) ? 16'd1 : raw_id;
        cmd.id_odd = raw_id[0];
        cmd.tick   = s_tdata[127:112];
        cmd.half   = fp_clamped >> 1;
    end

endmodule
`default_nettype wire

// ===== src/togc_back.sv =====
`default_nettype none
module togc_back #(
    parameter int GRID_BITS     = 8,
    parameter int MAX_LOOKAHEAD = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  togc_pkg::cfg_t     cfg,
    input  wire logic          q_valid,
    input  togc_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    output logic               init_busy,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [15:0]        m_tdata
);
    import togc_pkg::*;

    localparam int W  = 14 + GRID_BITS;
    localparam int AW = 2 * GRID_BITS;
    localparam int SW = $clog2(MAX_LOOKAHEAD + 1);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SQX    = 4'd2;
    localparam logic [3:0] ST_SQZ    = 4'd3;
    localparam logic [3:0] ST_SUM    = 4'd4;
    localparam logic [3:0] ST_SQRT   = 4'd5;
    localparam logic [3:0] ST_DLOAD  = 4'd6;
    localparam logic [3:0] ST_DIVX   = 4'd7;
    localparam logic [3:0] ST_DIVZ   = 4'd8;
    localparam logic [3:0] ST_PAINT  = 4'd9;
    localparam logic [3:0] ST_ISSUE  = 4'd10;
    localparam logic [3:0] ST_QEVAL  = 4'd11;
    localparam logic [3:0] ST_CEVAL  = 4'd12;
    localparam logic [3:0] ST_CLEAR  = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;
    localparam logic [3:0] ST_CWAIT  = 4'd15;

    logic [31:0] cells_mem [2**AW];
    logic [31:0] rd_data_reg;

    logic [3:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [W-1:0]       ax_reg, ax_next, az_reg, az_next;
    logic [31:0]        sq_x_reg, sq_x_next, sq_z_reg, sq_z_next;
    logic [47:0]        rad_reg, rad_next;
    logic [23:0]        root_reg, root_next;
    logic [25:0]        rem_reg, rem_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [37:0]        num_reg, num_next;
    logic [23:0]        drem_reg, drem_next;
    logic [37:0]        quo_reg, quo_next;
    logic signed [15:0] dx_reg, dx_next, dz_reg, dz_next;
    logic [SW-1:0]      steps_reg, steps_next, step_reg, step_next;
    logic [2:0]         ox_reg, ox_next, oz_reg, oz_next;
    logic [2:0]         lat_reg, lat_next;
    logic [1:0]         qstep_reg, qstep_next;
    logic [1:0]         cc_reg, cc_next;
    logic [2:0]         lc_reg, lc_next, rc_reg, rc_next;
    logic               occ_reg, occ_next;
    logic [AW-1:0]      sweep_reg, sweep_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    logic [31:0]        mem_wd;
    logic [AW-1:0]      rd_addr;

    logic [W-1:0]       fxe, fze, sx, sz;
    logic [W-1:0]       dxe, dze;
    logic [GRID_BITS-1:0] pcx, pcz;
    logic [2:0]         span;
    logic [27:0]        sq_rem_t, sq_trial;
    logic [24:0]        dtrial;
    logic [31:0]        s_sum;
    logic               hit;
    logic [15:0]        dt_chk;
    logic [SW-1:0]      steps_lim;
    result_t            res;

    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        abs16 = v[15] ? 16'(-v) : 16'(v);
    endfunction

    function automatic logic signed [15:0] norm_sat(input logic [37:0] q, input logic neg);
        logic [14:0] m;
        m = (q > 38'd16384) ? 15'd16384 : q[14:0];
        norm_sat = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    endfunction

    assign init_busy = (state_reg == ST_INIT);
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b0, out_data_reg};

    assign fxe  = {{(W-16){cmd_reg.fwd_x[15]}}, cmd_reg.fwd_x};
    assign fze  = {{(W-16){cmd_reg.fwd_z[15]}}, cmd_reg.fwd_z};
    assign dxe  = {{(W-16){dx_reg[15]}}, dx_reg};
    assign dze  = {{(W-16){dz_reg[15]}}, dz_reg};
    assign span = {cmd_reg.half[1:0], 1'b0};

    // query sample: center, left 1/2, right 1/2
    always_comb begin
        case (lat_reg)
            3'd1: begin
                sx = ax_reg - fze;
                sz = az_reg + fxe;
            end
            3'd2: begin
                sx = ax_reg - (fze << 1);
                sz = az_reg + (fxe << 1);
            end
            3'd3: begin
                sx = ax_reg + fze;
                sz = az_reg - fxe;
            end
            3'd4: begin
                sx = ax_reg + (fze << 1);
                sz = az_reg - (fxe << 1);
            end
            default: begin
                sx = ax_reg;
                sz = az_reg;
            end
        endcase
    end

    assign rd_addr = {sz[W-1:14], sx[W-1:14]};

    assign pcx = ax_reg[W-1:14] + GRID_BITS'(ox_reg) - GRID_BITS'(cmd_reg.half);
    assign pcz = az_reg[W-1:14] + GRID_BITS'(oz_reg) - GRID_BITS'(cmd_reg.half);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = sweep_reg;
        mem_wd = 32'd0;
        if (state_reg == ST_PAINT) begin
            mem_we = 1'b1;
            mem_wa = {pcz, pcx};
            mem_wd = {cmd_reg.uid, cmd_reg.tick};
        end else if (state_reg == ST_INIT || state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end
    end

    assign sq_rem_t = {rem_reg, rad_reg[47:46]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign dtrial   = {drem_reg, num_reg[37]};
    assign s_sum    = sq_x_reg + sq_z_reg;
    assign dt_chk   = cmd_reg.tick - rd_data_reg[15:0];
    assign hit      = (dt_chk < cfg.decay_ticks) && (rd_data_reg[31:16] != cmd_reg.uid);

    assign steps_lim = ({1'b0, cfg.lookahead_cells} > 5'(MAX_LOOKAHEAD))
                     ? SW'(MAX_LOOKAHEAD) : SW'(cfg.lookahead_cells);

    always_comb begin
        res = '0;
        if (cmd_reg.action == ACT_QUERY) begin
            res.center_count = cc_reg;
            res.left_count   = lc_reg;
            res.right_count  = rc_reg;
            if (cc_reg == 2'd0) begin
                res.steer = STEER_NONE;
            end else if (lc_reg > rc_reg) begin
                res.steer = STEER_RIGHT;
            end else if (rc_reg > lc_reg) begin
                res.steer = STEER_LEFT;
            end else begin
                res.steer = cmd_reg.id_odd ? STEER_RIGHT : STEER_LEFT;
            end
        end else if (cmd_reg.action == ACT_CHECK) begin
            res.occupied = occ_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ax_next        = ax_reg;
        az_next        = az_reg;
        sq_x_next      = sq_x_reg;
        sq_z_next      = sq_z_reg;
        rad_next       = rad_reg;
        root_next      = root_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        drem_next      = drem_reg;
        quo_next       = quo_reg;
        dx_next        = dx_reg;
        dz_next        = dz_reg;
        steps_next     = steps_reg;
        step_next      = step_reg;
        ox_next        = ox_reg;
        oz_next        = oz_reg;
        lat_next       = lat_reg;
        qstep_next     = qstep_reg;
        cc_next        = cc_reg;
        lc_next        = lc_reg;
        rc_next        = rc_reg;
        occ_next       = occ_reg;
        sweep_next     = sweep_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_INIT, ST_CLEAR: begin
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == '1) begin
                    state_next = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next   = q_cmd;
                    ax_next    = W'({q_cmd.pos_x, 6'b0});
                    az_next    = W'({q_cmd.pos_z, 6'b0});
                    steps_next = '0;
                    step_next  = '0;
                    ox_next    = '0;
                    oz_next    = '0;
                    lat_next   = '0;
                    qstep_next = '0;
                    cc_next    = '0;
                    lc_next    = '0;
                    rc_next    = '0;
                    occ_next   = 1'b0;
                    sweep_next = '0;
                    case (q_cmd.action)
                        ACT_MARK:  state_next = ST_SQX;
                        ACT_QUERY: begin
                            ax_next = W'({q_cmd.pos_x, 6'b0})
                                    + {{(W-16){q_cmd.fwd_x[15]}}, q_cmd.fwd_x};
                            az_next = W'({q_cmd.pos_z, 6'b0})
                                    + {{(W-16){q_cmd.fwd_z[15]}}, q_cmd.fwd_z};
                            state_next = ST_ISSUE;
                        end
                        ACT_CHECK: state_next = ST_ISSUE;
                        default:   state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_SQX: begin
                sq_x_next  = 32'(cmd_reg.vel_x * cmd_reg.vel_x);
                state_next = ST_SQZ;
            end
            ST_SQZ: begin
                sq_z_next  = 32'(cmd_reg.vel_z * cmd_reg.vel_z);
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (s_sum == 32'd0 || s_sum < {16'd0, cfg.motion_threshold}) begin
                    state_next = ST_PAINT;
                end else begin
                    rad_next   = {s_sum, 16'd0};
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                rad_next = rad_reg << 2;
                if (sq_rem_t >= sq_trial) begin
                    rem_next  = 26'(sq_rem_t - sq_trial);
                    root_next = {root_reg[22:0], 1'b1};
                end else begin
                    rem_next  = sq_rem_t[25:0];
                    root_next = {root_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd23) begin
                    state_next = ST_DLOAD;
                end
            end
            ST_DLOAD: begin
                num_next   = {abs16(cmd_reg.vel_x), 22'd0} + 38'(root_reg[23:1]);
                drem_next  = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIVX;
            end
            ST_DIVX, ST_DIVZ: begin
                num_next = num_reg << 1;
                if (dtrial >= {1'b0, root_reg}) begin
                    drem_next = 24'(dtrial - {1'b0, root_reg});
                    quo_next  = {quo_reg[36:0], 1'b1};
                end else begin
                    drem_next = dtrial[23:0];
                    quo_next  = {quo_reg[36:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd37) begin
                    cnt_next  = '0;
                    drem_next = '0;
                    if (state_reg == ST_DIVX) begin
                        dx_next    = norm_sat(quo_next, cmd_reg.vel_x[15]);
                        num_next   = {abs16(cmd_reg.vel_z), 22'd0} + 38'(root_reg[23:1]);
                        state_next = ST_DIVZ;
                    end else begin
                        dz_next    = norm_sat(quo_next, cmd_reg.vel_z[15]);
                        steps_next = steps_lim;
                        state_next = ST_PAINT;
                    end
                    quo_next = '0;
                end
            end
            ST_PAINT: begin
                if (oz_reg == span) begin
                    oz_next = '0;
                    if (ox_reg == span) begin
                        ox_next = '0;
                        if (step_reg == steps_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            step_next = step_reg + 1'b1;
                            ax_next   = ax_reg + dxe;
                            az_next   = az_reg + dze;
                        end
                    end else begin
                        ox_next = ox_reg + 1'b1;
                    end
                end else begin
                    oz_next = oz_reg + 1'b1;
                end
            end
            ST_ISSUE: begin
                state_next = ST_CWAIT;
            end
            ST_CWAIT: begin
                state_next = (cmd_reg.action == ACT_QUERY) ? ST_QEVAL : ST_CEVAL;
            end
            ST_QEVAL: begin
                if (hit) begin
                    if (lat_reg == 3'd0) begin
                        cc_next = cc_reg + 1'b1;
                    end else if (lat_reg == 3'd1 || lat_reg == 3'd2) begin
                        lc_next = lc_reg + 1'b1;
                    end else begin
                        rc_next = rc_reg + 1'b1;
                    end
                end
                state_next = ST_ISSUE;
                if (lat_reg == 3'd4) begin
                    lat_next = '0;
                    if (qstep_reg == 2'd2) begin
                        state_next = ST_DONE;
                    end else begin
                        qstep_next = qstep_reg + 1'b1;
                        ax_next    = ax_reg + fxe;
                        az_next    = az_reg + fze;
                    end
                end else begin
                    lat_next = lat_reg + 1'b1;
                end
            end
            ST_CEVAL: begin
                occ_next   = hit && (rd_data_reg[31:16] != 16'd0);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = res;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ax_reg       <= ax_next;
        az_reg       <= az_next;
        sq_x_reg     <= sq_x_next;
        sq_z_reg     <= sq_z_next;
        rad_reg      <= rad_next;
        root_reg     <= root_next;
        rem_reg      <= rem_next;
        cnt_reg      <= cnt_next;
        num_reg      <= num_next;
        drem_reg     <= drem_next;
        quo_reg      <= quo_next;
        dx_reg       <= dx_next;
        dz_reg       <= dz_next;
        steps_reg    <= steps_next;
        step_reg     <= step_next;
        ox_reg       <= ox_next;
        oz_reg       <= oz_next;
        lat_reg      <= lat_next;
        qstep_reg    <= qstep_next;
        cc_reg       <= cc_next;
        lc_reg       <= lc_next;
        rc_reg       <= rc_next;
        occ_reg      <= occ_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            cells_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= cells_mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/transient_occupancy_grid_core.sv =====
// Mark: a slow unit paints only its footprint square; a moving unit paints it at L+1 points, since
// squaring both velocities, 24 root iterations and 2x38 divide iterations come before painting.
// One transaction at a time in the back end; a 4-entry queue decouples input acceptance.
// Reset: synchronous active-low; afterwards the cell store is zeroed one entry per cycle
// (2^(2*GRID_BITS) entries, 65536 by default) with s_tready low; APB writes still taken.
`default_nettype none
module transient_occupancy_grid_core #(
    parameter int GRID_BITS     = 8,
    parameter int MAX_FOOTPRINT = 7,
    parameter int MAX_LOOKAHEAD = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // pos_x, pos_z, vel_x, vel_z, fwd_x, fwd_z, unit_id, now_tick, footprint, zero pad
    input  wire logic [135:0]  s_tdata,
    // action
    input  wire logic [1:0]    s_tuser,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // steer, occupied, center_count, left_count, right_count, zero pad
    output logic [15:0]        m_tdata,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import togc_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd, q_cmd;
    logic push, q_full, q_valid, q_pop, init_busy;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.decay_ticks      <= 16'd15;
            cfg_reg.lookahead_cells  <= 4'd5;
            cfg_reg.motion_threshold <= 16'd655;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_DECAY:  cfg_reg.decay_ticks      <= pwdata[15:0];
                REG_LOOK:   cfg_reg.lookahead_cells  <= pwdata[3:0];
                REG_THRESH: cfg_reg.motion_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_DECAY:  prdata = {16'd0, cfg_reg.decay_ticks};
            REG_LOOK:   prdata = {28'd0, cfg_reg.lookahead_cells};
            REG_THRESH: prdata = {16'd0, cfg_reg.motion_threshold};
            default:    prdata = 32'd0;
        endcase
    end

    togc_front #(
        .MAX_FOOTPRINT (MAX_FOOTPRINT)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .init_busy (init_busy),
        .push      (push),
        .cmd       (front_cmd)
    );

    togc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .din     (front_cmd),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .dout    (q_cmd)
    );

    togc_back #(
        .GRID_BITS     (GRID_BITS),
        .MAX_LOOKAHEAD (MAX_LOOKAHEAD)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire

// ===== src/togc_checker.sv =====
`default_nettype none
`include "transient_occupancy_grid_core_macros.svh"
module togc_checker (
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_tvalid,
    input wire logic          s_tready,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [15:0]   m_tdata
);
    logic [3:0] pending_reg, pending_next;
    logic       s_fire, m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    always_comb begin
        pending_next = pending_reg;
        if (s_fire && !m_fire) begin
            pending_next = pending_reg + 1'b1;
        end else if (m_fire && !s_fire) begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `TOGC_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `TOGC_ASSERT_NOW(a_no_orphan_result, m_tvalid, pending_reg != 4'd0)
    `TOGC_ASSERT_NEXT_ALWAYS(a_reset_sweep, !aresetn, !s_tready && !m_tvalid)

endmodule

bind transient_occupancy_grid_core togc_checker u_checker (.*);
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import togc_pkg::*;

    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [1:0]         action;
        logic [15:0]        pos_x;
        logic [15:0]        pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_z;
        logic signed [15:0] fwd_x;
        logic signed [15:0] fwd_z;
        logic [15:0]        unit_id;
        logic [15:0]        now_tick;
        logic [2:0]         footprint;
    } grid_cmd_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [135:0]  s_tdata = '0;
    logic [1:0]    s_tuser = '0;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [15:0]   m_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [3:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    transient_occupancy_grid_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 aclk = ~aclk;

    // grid shadow and register copies
    logic [31:0] cell_words [65536];
    logic [15:0] decay_reg = 16'd15;
    logic [3:0]  look_reg = 4'd5;
    logic [15:0] thresh_reg = 16'd655;

    grid_cmd_t   cmd_queue [$];
    logic [15:0] expected_results [$];
    int          error_count = 0;
    int          cmds_sent = 0;
    int          results_seen = 0;
    longint      cycle_count = 0;
    logic [15:0] tick_base = 16'd100;

    function automatic logic [7:0] cell_of(longint p);
        logic [63:0] u;
        u = p;
        return u[21:14];
    endfunction

    function automatic void paint_square(logic [7:0] gx, logic [7:0] gz, int half,
                                         logic [31:0] word);
        logic [7:0] cx, cz;
        for (int dx = -half; dx <= half; dx++) begin
            for (int dz = -half; dz <= half; dz++) begin
                cx = 8'(int'(gx) + dx);
                cz = 8'(int'(gz) + dz);
                cell_words[{cz, cx}] = word;
            end
        end
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_comp(longint v, longint unsigned mag);
        longint unsigned a, d;
        a = (v < 0) ? -v : v;
        d = ((a << 22) + mag / 2) / mag;
        if (d > 16384) d = 16384;
        return (v < 0) ? -longint'(d) : longint'(d);
    endfunction

    function automatic logic foreign_recent(logic [7:0] gx, logic [7:0] gz,
                                            logic [15:0] t, logic [15:0] uid);
        logic [31:0] w;
        logic [15:0] dt;
        w = cell_words[{gz, gx}];
        dt = t - w[15:0];
        return (dt < decay_reg) && (w[31:16] != uid);
    endfunction

    // applies one command to the shadow grid and returns the result word
    function automatic logic [15:0] grid_step(grid_cmd_t c);
        logic [15:0] uid, dt;
        logic [31:0] word;
        longint px14, pz14, fx, fz, vx, vz, ax, az, dx, dz;
        longint unsigned s, mag;
        int half, steps;
        logic [1:0] cc, steer;
        logic [2:0] lc, rc;
        logic occ;
        uid = (c.unit_id == 0) ? 16'd1 : c.unit_id;
        px14 = longint'(c.pos_x) << 6;
        pz14 = longint'(c.pos_z) << 6;
        fx = c.fwd_x; fz = c.fwd_z; vx = c.vel_x; vz = c.vel_z;
        cc = 0; lc = 0; rc = 0; steer = STEER_NONE; occ = 0;
        case (c.action)
            ACT_MARK: begin
                word = {uid, c.now_tick};
                half = c.footprint / 2;
                paint_square(cell_of(px14), cell_of(pz14), half, word);
                s = vx * vx + vz * vz;
                if (s != 0 && s >= thresh_reg) begin
                    mag = int_sqrt(s << 16);
                    dx = unit_comp(vx, mag);
                    dz = unit_comp(vz, mag);
                    steps = (look_reg > 8) ? 8 : look_reg;
                    for (int i = 1; i <= steps; i++)
                        paint_square(cell_of(px14 + dx * i), cell_of(pz14 + dz * i),
                                     half, word);
                end
            end
            ACT_QUERY: begin
                for (int i = 1; i <= 3; i++) begin
                    ax = px14 + fx * i;
                    az = pz14 + fz * i;
                    if (foreign_recent(cell_of(ax), cell_of(az), c.now_tick, uid)) cc++;
                    for (int l = 1; l <= 2; l++) begin
                        if (foreign_recent(cell_of(ax - fz * l), cell_of(az + fx * l),
                                           c.now_tick, uid)) lc++;
                        if (foreign_recent(cell_of(ax + fz * l), cell_of(az - fx * l),
                                           c.now_tick, uid)) rc++;
                    end
                end
                if (cc == 0) steer = STEER_NONE;
                else if (lc > rc) steer = STEER_RIGHT;
                else if (rc > lc) steer = STEER_LEFT;
                else steer = c.unit_id[0] ? STEER_RIGHT : STEER_LEFT;
            end
            ACT_CHECK: begin
                word = cell_words[{cell_of(pz14), cell_of(px14)}];
                dt = c.now_tick - word[15:0];
                occ = (dt < decay_reg) && (word[31:16] != 0) && (word[31:16] != uid);
            end
            default: begin
                foreach (cell_words[k]) cell_words[k] = '0;
            end
        endcase
        return {5'b0, rc, lc, cc, occ, steer};
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp,
                 results_seen);
        error_count++;
    endtask

    // driver
    int  send_gap = 0;
    logic burst;
    always @(posedge aclk) begin
        grid_cmd_t c;
        logic nv;
        burst = ((cmds_sent / 64) % 4) == 3;
        if (s_tvalid && s_tready) begin
            c.action = s_tuser;
            {c.footprint, c.now_tick, c.unit_id, c.fwd_z, c.fwd_x, c.vel_z, c.vel_x,
             c.pos_z, c.pos_x} = s_tdata[130:0];
            expected_results.push_back(grid_step(c));
            cmds_sent++;
            send_gap = burst ? 0 : $urandom_range(0, 3);
        end
        nv = s_tvalid;
        if (!aresetn) begin
            nv = 1'b0;
        end else if (s_tvalid && !s_tready) begin
            nv = 1'b1;
        end else if (send_gap > 0) begin
            send_gap--;
            nv = 1'b0;
        end else if (cmd_queue.size() > 0) begin
            c = cmd_queue.pop_front();
            s_tuser <= c.action;
            s_tdata <= {5'b0, c.footprint, c.now_tick, c.unit_id, c.fwd_z, c.fwd_x,
                        c.vel_z, c.vel_x, c.pos_z, c.pos_x};
            nv = 1'b1;
        end else begin
            nv = 1'b0;
        end
        s_tvalid <= nv;
    end

    // monitor
    int recv_stall = 0;
    int hold_off = 0;
    always @(posedge aclk) begin
        logic [15:0] exp;
        logic nr;
        if (m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result transaction %h", m_tdata);
                error_count++;
            end else begin
                exp = expected_results.pop_front();
                if (m_tdata[1:0] != exp[1:0]) report_mismatch("steer", m_tdata[1:0], exp[1:0]);
                if (m_tdata[2] != exp[2]) report_mismatch("occupied", m_tdata[2], exp[2]);
                if (m_tdata[4:3] != exp[4:3]) report_mismatch("center", m_tdata[4:3], exp[4:3]);
                if (m_tdata[7:5] != exp[7:5]) report_mismatch("left", m_tdata[7:5], exp[7:5]);
                if (m_tdata[10:8] != exp[10:8]) report_mismatch("right", m_tdata[10:8], exp[10:8]);
                if (m_tdata[15:11] != 0) report_mismatch("pad", m_tdata[15:11], 0);
            end
            results_seen++;
            recv_stall = burst ? 0 : $urandom_range(0, 3);
            if (results_seen == 300) hold_off = 600;
        end
        if (hold_off > 0) begin
            hold_off--;
            nr = 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            nr = 1'b0;
        end else begin
            nr = 1'b1;
        end
        m_tready <= nr;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_DECAY: decay_reg = val[15:0];
            REG_LOOK:  look_reg = val[3:0];
            default:   thresh_reg = val[15:0];
        endcase
    endtask

    task automatic wait_drained();
        wait (cmd_queue.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (10) @(posedge aclk);
    endtask

    function automatic grid_cmd_t make_cmd(logic [1:0] act, logic [15:0] px, logic [15:0] pz,
                                           logic [15:0] vx, logic [15:0] vz,
                                           logic [15:0] fx, logic [15:0] fz,
                                           logic [15:0] id, logic [15:0] t, logic [2:0] fp);
        grid_cmd_t c;
        c.action = act; c.pos_x = px; c.pos_z = pz; c.vel_x = vx; c.vel_z = vz;
        c.fwd_x = fx; c.fwd_z = fz; c.unit_id = id; c.now_tick = t; c.footprint = fp;
        return c;
    endfunction

    function automatic logic [15:0] near_pos();
        logic [7:0] grid_pos;
        if ($urandom_range(0, 9) < 8) begin
            grid_pos = 8'($urandom_range(0, 15) - 4);
            return {grid_pos, 8'($urandom)};
        end
        return 16'($urandom);
    endfunction

    function automatic logic signed [15:0] rand_vel();
        case ($urandom_range(0, 9))
            0: return 0;
            1, 2: return 16'($urandom);
            default: return $signed(17'($urandom_range(0, 1024))) - 512;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_fwd();
        case ($urandom_range(0, 9))
            0: return 16'($urandom);
            1: return ($urandom_range(0, 1)) ? 16'sd16384 : -16'sd16384;
            default: return $signed(17'($urandom_range(0, 32768))) - 16384;
        endcase
    endfunction

    function automatic grid_cmd_t rand_cmd();
        int r;
        logic [1:0] act;
        logic [15:0] id, t;
        r = $urandom_range(0, 999);
        if (r < 2) act = ACT_CLEAR;
        else if (r < 420) act = ACT_MARK;
        else if (r < 720) act = ACT_QUERY;
        else act = ACT_CHECK;
        id = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 3)) : 16'($urandom);
        t = ($urandom_range(0, 19) == 0) ? 16'($urandom) : tick_base + $urandom_range(0, 20);
        return make_cmd(act, near_pos(), near_pos(), rand_vel(), rand_vel(), rand_fwd(),
                        rand_fwd(), id, t, 3'($urandom));
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 29) == 0) tick_base = tick_base + $urandom_range(1, 40);
            cmd_queue.push_back(rand_cmd());
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // empty grid: unmarked cells count while tick < decay
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'h0500, 16'h0500, 0, 0, 16'sd16384, 0,
                                     16'd2, 16'd3, 0));
        cmd_queue.push_back(make_cmd(ACT_CHECK, 16'h0500, 16'h0500, 0, 0, 0, 0, 0, 16'd3, 0));
        cmd_queue.push_back(make_cmd(ACT_MARK, 16'h0000, 16'h0000, 0, 0, 0, 0, 0, 16'd100, 3'd7));
        cmd_queue.push_back(make_cmd(ACT_MARK, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 0, 0,
                                     16'hFFFF, 16'hFFFF, 3'd0));
        cmd_queue.push_back(make_cmd(ACT_MARK, 16'h0A80, 16'h0380, 16'sd256, 16'sd0, 0, 0,
                                     16'd3, 16'd101, 3'd2));
        cmd_queue.push_back(make_cmd(ACT_MARK, 16'h0300, 16'h0300, 16'sd10, 16'sd5, 0, 0,
                                     16'd4, 16'd101, 3'd3));
        cmd_queue.push_back(make_cmd(ACT_CHECK, 16'h0000, 16'h0000, 0, 0, 0, 0, 16'd1, 16'd105, 0));
        cmd_queue.push_back(make_cmd(ACT_CHECK, 16'h0180, 16'hFF00, 0, 0, 0, 0, 16'd2, 16'd105, 0));
        cmd_queue.push_back(make_cmd(ACT_CHECK, 16'hFF00, 16'hFF00, 0, 0, 0, 0, 16'd9, 16'hFFFF, 0));
        // tie cases with odd and even ids, wrap below zero
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'hFF00, 16'h0000, 0, 0, 16'sd16384, 0,
                                     16'd5, 16'd102, 0));
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'hFF00, 16'h0000, 0, 0, 16'sd16384, 0,
                                     16'd6, 16'd102, 0));
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'h0100, 16'h0100, 0, 0, -16'sd16384,
                                     -16'sd16384, 16'd7, 16'd103, 0));
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'h0800, 16'h0300, 0, 0, 0, 16'sd16384,
                                     16'd0, 16'd104, 0));
        cmd_queue.push_back(make_cmd(ACT_QUERY, 16'h0000, 16'h0000, 0, 0, 16'h7FFF, 16'h8000,
                                     16'd8, 16'd104, 0));
        cmd_queue.push_back(make_cmd(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        cmd_queue.push_back(make_cmd(ACT_CHECK, 16'h0000, 16'h0000, 0, 0, 0, 0, 16'd1, 16'd105, 0));
        wait_drained();
        run_random(400);
        apb_write(REG_DECAY, 32'd65535);
        apb_write(REG_LOOK, 32'd8);
        apb_write(REG_THRESH, 32'd0);
        run_random(300);
        apb_write(REG_DECAY, 32'd1);
        apb_write(REG_LOOK, 32'd0);
        apb_write(REG_THRESH, 32'd65535);
        run_random(250);
        apb_write(REG_DECAY, $urandom_range(2, 40));
        apb_write(REG_LOOK, 32'd15);
        apb_write(REG_THRESH, $urandom_range(0, 70000));
        run_random(300);
        apb_write(REG_DECAY, 32'd15);
        apb_write(REG_LOOK, 32'd5);
        apb_write(REG_THRESH, 32'd655);
        run_random(330);
        repeat (200) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+src
src/togc_pkg.sv
src/togc_queue.sv
src/togc_front.sv
src/togc_back.sv
src/transient_occupancy_grid_core.sv
src/togc_checker.sv
bench/testbench.sv
